@@ design/puf_pkg.sv @@
// Shared types, codes and prediction functions for the PNG RGB8 scanline unfilter.
// No dependencies; used by the top level, front end and back end through scoped names.
package puf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int IMG_WIDTH_W   = 11;
  localparam int IMG_HEIGHT_W  = 16;
  localparam int COLUMN_OUT_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [7:0] FILTER_MAX_CODE = 8'd4;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filter_t;

  typedef enum logic [3:0] {
    PH_FILTER = 4'b0001,
    PH_RED    = 4'b0010,
    PH_GREEN  = 4'b0100,
    PH_BLUE   = 4'b1000
  } phase_t;

  // One assembled pixel request handed from front to back
  typedef struct packed {
    logic [23:0] raw;
    filter_t     filter;
    logic        first_col;
    logic        row_first;
    logic        last_col;
    logic        last_row;
  } job_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [7:0]        r;
    // p = a + b - c, so |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    pa = $signed({2'b00, b}) - $signed({2'b00, c});
    pb = $signed({2'b00, a}) - $signed({2'b00, c});
    pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc) r = b;
    else r = c;
    return r;
  endfunction

  function automatic logic [7:0] predict(input filter_t f, input logic [7:0] a,
                                         input logic [7:0] b, input logic [7:0] c);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, a} + {1'b0, b};
    case (f)
      FLT_SUB:   r = a;
      FLT_UP:    r = b;
      FLT_AVG:   r = sum[8:1];
      FLT_PAETH: r = paeth(a, b, c);
      default:   r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/png_rgb8_scanline_unfilter_unit.sv @@
// PNG 8-bit RGB scanline unfilter, top level: front end, request queue, back end.
// Depends on puf_pkg, puf_front, puf_queue and puf_back.
//
// Takes one stream byte per cycle, sustained while the queue has room: per row
// a filter byte (above 4 acts as None) then three bytes per pixel, and gives
// one reconstructed pixel on each third channel byte with its column and
// row/image end flags. The back end takes one pixel at a time (line buffer
// read, then reconstruct and write back), and a two-entry queue lets the input
// run on while the output stalls. The line buffer holds MAX_WIDTH pixels and
// is not cleared; the first row of each image sees zero above it.
// Configuration must be written while idle; the block does not enforce this.
module png_rgb8_scanline_unfilter_unit #(
  parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [puf_pkg::COLUMN_OUT_W-1:0]    out_column,
  output logic                                out_row_end,
  output logic                                out_image_end,
  input  logic                                cfg_we,
  input  logic [puf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [puf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int JOB_W  = $bits(puf_pkg::job_t);
  localparam int DATA_W = JOB_W + CW;

  logic                push_valid;
  puf_pkg::job_t       push_job;
  logic [CW-1:0]       push_col;
  logic                q_full;
  logic                q_valid;
  logic                pop;
  logic [DATA_W-1:0]   q_head;
  logic                back_busy;
  puf_pkg::job_t       head_job;
  logic [CW-1:0]       head_col;

  assign head_job = puf_pkg::job_t'(q_head[DATA_W-1:CW]);
  assign head_col = q_head[CW-1:0];

  puf_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .push_valid   (push_valid),
    .push_job     (push_job),
    .push_col     (push_col)
  );

  puf_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (puf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_job, push_col}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  puf_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_job         (head_job),
    .q_col         (head_col),
    .pop           (pop),
    .busy          (back_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_column    (out_column),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end)
  );

  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_end |-> out_row_end)
    else $error("image end flagged away from a row end");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> !q_full)
    else $error("pixel request pushed into a full queue");

  a_result_from_back: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(back_busy))
    else $error("result appeared without a request in the back end");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> back_busy)
    else $error("popped request not held by the back end");

endmodule

@@ design/puf_queue.sv @@
// Small request queue between the byte front end and the pixel back end.
// Depends on nothing but its parameters.
module puf_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r, count_nxt;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

@@ design/puf_front.sv @@
// Front end: takes stream bytes, tracks filter/channel phase, row and column,
// and issues one pixel request per three channel bytes. Uses puf_pkg.
module puf_front #(
  parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF,
  parameter int CW        = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             cfg_we,
  input  logic [puf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [puf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             q_full,
  output logic                             push_valid,
  output puf_pkg::job_t                    push_job,
  output logic [CW-1:0]                    push_col
);

  // wide enough for column+1, the width register and MAX_WIDTH
  localparam int LW = (CW + 1 > puf_pkg::IMG_WIDTH_W) ? CW + 2 : puf_pkg::IMG_WIDTH_W + 1;
  localparam int HW = puf_pkg::IMG_HEIGHT_W;

  logic [puf_pkg::IMG_WIDTH_W-1:0] width_r, width_nxt;
  logic [HW-1:0]                   height_r, height_nxt;
  puf_pkg::phase_t                 phase_r, phase_nxt;
  puf_pkg::filter_t                filter_r, filter_nxt;
  logic [CW-1:0]                   col_r, col_nxt;
  logic [HW-1:0]                   row_r, row_nxt;
  logic [15:0]                     partial_r, partial_nxt;

  logic          accept;
  logic [LW-1:0] col_inc;
  logic [HW:0]   row_inc;
  logic          last_col;
  logic          last_row;

  assign in_ready = (phase_r != puf_pkg::PH_BLUE) || !q_full;
  assign accept   = in_valid && in_ready;

  // a width of 0 acts as 1, beyond MAX_WIDTH as MAX_WIDTH; a height of 0 acts as 1
  assign col_inc  = LW'(col_r) + 1'b1;
  assign row_inc  = {1'b0, row_r} + 1'b1;
  assign last_col = (col_inc >= LW'(width_r)) || (col_inc >= LW'(MAX_WIDTH));
  assign last_row = last_col && (row_inc >= {1'b0, height_r});

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      case (cfg_index)
        puf_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_wdata[puf_pkg::IMG_WIDTH_W-1:0];
        puf_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_wdata[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    filter_nxt  = filter_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    partial_nxt = partial_r;
    if (accept) begin
      case (phase_r)
        puf_pkg::PH_FILTER: begin
          filter_nxt = (in_data_byte > puf_pkg::FILTER_MAX_CODE) ? puf_pkg::FLT_NONE :
                       puf_pkg::filter_t'(in_data_byte[2:0]);
          col_nxt    = '0;
          phase_nxt  = puf_pkg::PH_RED;
        end
        puf_pkg::PH_RED: begin
          partial_nxt[15:8] = in_data_byte;
          phase_nxt         = puf_pkg::PH_GREEN;
        end
        puf_pkg::PH_GREEN: begin
          partial_nxt[7:0] = in_data_byte;
          phase_nxt        = puf_pkg::PH_BLUE;
        end
        puf_pkg::PH_BLUE: begin
          if (last_col) begin
            phase_nxt = puf_pkg::PH_FILTER;
            col_nxt   = '0;
            row_nxt   = last_row ? '0 : row_inc[HW-1:0];
          end else begin
            phase_nxt = puf_pkg::PH_RED;
            col_nxt   = col_inc[CW-1:0];
          end
        end
        default: phase_nxt = puf_pkg::PH_FILTER;
      endcase
    end
  end

  assign push_valid         = accept && (phase_r == puf_pkg::PH_BLUE);
  assign push_col           = col_r;
  assign push_job.raw       = {partial_r, in_data_byte};
  assign push_job.filter    = filter_r;
  assign push_job.first_col = (col_r == '0);
  assign push_job.row_first = (row_r == '0);
  assign push_job.last_col  = last_col;
  assign push_job.last_row  = last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= puf_pkg::IMG_WIDTH_W'(1);
      height_r  <= HW'(1);
      phase_r   <= puf_pkg::PH_FILTER;
      filter_r  <= puf_pkg::FLT_NONE;
      col_r     <= '0;
      row_r     <= '0;
      partial_r <= '0;
    end else begin
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      phase_r   <= phase_nxt;
      filter_r  <= filter_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

@@ design/puf_back.sv @@
// Back end: reads the row above from the line buffer, reconstructs the pixel,
// writes it back and holds it in the output register. Uses puf_pkg.
module puf_back #(
  parameter int MAX_WIDTH = puf_pkg::MAX_WIDTH_DEF,
  parameter int CW        = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  puf_pkg::job_t                       q_job,
  input  logic [CW-1:0]                       q_col,
  output logic                                pop,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_red,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_blue,
  output logic [puf_pkg::COLUMN_OUT_W-1:0]    out_column,
  output logic                                out_row_end,
  output logic                                out_image_end
);

  localparam int XW = CW + puf_pkg::COLUMN_OUT_W;

  logic [23:0] line_mem [MAX_WIDTH];

  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  puf_pkg::job_t job_r;
  logic [CW-1:0] col_r;
  logic [23:0]   rd_r;
  logic [23:0]   left_r;
  logic [23:0]   ul_r;
  logic [23:0]   px_r;
  logic [puf_pkg::COLUMN_OUT_W-1:0] column_r;
  logic          row_end_r;
  logic          image_end_r;

  logic          done;
  logic [23:0]   up;
  logic [23:0]   a_px;
  logic [23:0]   c_px;
  logic [23:0]   px;
  logic [XW-1:0] col_ext;

  // one request in flight: the buffer write of a pixel always lands before
  // the next read, so a one-pixel-wide image needs no bypass
  assign pop  = q_valid && !busy_r;
  assign done = busy_r && (!out_valid_r || out_ready);
  assign busy = busy_r;

  assign up   = job_r.row_first ? '0 : rd_r;
  assign a_px = job_r.first_col ? '0 : left_r;
  assign c_px = job_r.first_col ? '0 : ul_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      px[8*k +: 8] = job_r.raw[8*k +: 8] +
                     puf_pkg::predict(job_r.filter, a_px[8*k +: 8], up[8*k +: 8],
                                      c_px[8*k +: 8]);
    end
  end

  assign col_ext = XW'(col_r);

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (pop) busy_nxt = 1'b1;
    else if (done) busy_nxt = 1'b0;
    if (done) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_job;
      col_r <= q_col;
      rd_r  <= line_mem[q_col];
    end
    if (done) begin
      line_mem[col_r] <= px;
      left_r          <= px;
      ul_r            <= up;
      px_r            <= px;
      column_r        <= col_ext[puf_pkg::COLUMN_OUT_W-1:0];
      row_end_r       <= job_r.last_col;
      image_end_r     <= job_r.last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = px_r[23:16];
  assign out_green     = px_r[15:8];
  assign out_blue      = px_r[7:0];
  assign out_column    = column_r;
  assign out_row_end   = row_end_r;
  assign out_image_end = image_end_r;

endmodule

@@ tb/sv/unfilter_pixel_checker.sv @@
// Pixel checker for the PNG RGB8 scanline unfilter: watches the byte, pixel and register ports,
// predicts each reconstructed pixel and compares it field by field with what the block gives.
// Depends on puf_pkg for widths, register indexes and the filter and phase codes.
module unfilter_pixel_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [7:0]                       in_data_byte,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [7:0]                       out_red,
  input  logic [7:0]                       out_green,
  input  logic [7:0]                       out_blue,
  input  logic [puf_pkg::COLUMN_OUT_W-1:0] out_column,
  input  logic                             out_row_end,
  input  logic                             out_image_end,
  input  logic                             cfg_we,
  input  logic [puf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [puf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                               fail_count,
  output int                               pending,
  output int                               pixels_checked
);

  typedef struct packed {
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [puf_pkg::COLUMN_OUT_W-1:0] column;
    logic                             row_end;
    logic                             image_end;
  } pixel_t;

  pixel_t                           pixel_due_q[$];
  logic [23:0]                      line_buf [puf_pkg::MAX_WIDTH_DEF];
  logic [23:0]                      left_px;
  logic [23:0]                      upleft_px;
  logic [15:0]                      red_green;
  logic [puf_pkg::COLUMN_OUT_W-1:0] col;
  logic [15:0]                      row;
  puf_pkg::filter_t                 row_flt;
  puf_pkg::phase_t                  phase;
  logic [puf_pkg::IMG_WIDTH_W-1:0]  width_reg;
  logic [puf_pkg::IMG_HEIGHT_W-1:0] height_reg;

  function automatic logic [7:0] filter_prediction(input puf_pkg::filter_t f,
                                                   input logic [7:0] a,
                                                   input logic [7:0] b, input logic [7:0] c);
    int p;
    int da;
    int db;
    int dc;
    p  = int'(a) + int'(b) - int'(c);
    da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    case (f)
      puf_pkg::FLT_SUB:   return a;
      puf_pkg::FLT_UP:    return b;
      puf_pkg::FLT_AVG:   return 8'((int'(a) + int'(b)) >> 1);
      puf_pkg::FLT_PAETH: begin
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
      end
      default:   return 8'd0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("MISMATCH %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("pixel %0d %s: expected %0h, got %0h",
                                pixels_checked, name, want, got));
  endtask

  always @(posedge clk) begin
    pixel_t      want;
    logic [23:0] up_px;
    logic [23:0] raw;
    logic [23:0] px;
    int          w;
    int          h;
    logic        last_col;
    logic        last_row;
    if (!rst_n) begin
      left_px        = '0;
      upleft_px      = '0;
      red_green      = '0;
      col            = '0;
      row            = '0;
      row_flt        = puf_pkg::FLT_NONE;
      phase          = puf_pkg::PH_FILTER;
      width_reg      = puf_pkg::IMG_WIDTH_W'(1);
      height_reg     = puf_pkg::IMG_HEIGHT_W'(1);
      fail_count     = 0;
      pixels_checked = 0;
      pixel_due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == puf_pkg::REG_IMAGE_WIDTH)
          width_reg = cfg_wdata[puf_pkg::IMG_WIDTH_W-1:0];
        else if (cfg_index == puf_pkg::REG_IMAGE_HEIGHT)
          height_reg = cfg_wdata[puf_pkg::IMG_HEIGHT_W-1:0];
      end

      if (in_valid && in_ready) begin
        case (phase)
          puf_pkg::PH_FILTER: begin
            // codes above Paeth fall back to no filtering
            row_flt   = (in_data_byte > puf_pkg::FILTER_MAX_CODE) ? puf_pkg::FLT_NONE
                        : puf_pkg::filter_t'(in_data_byte[2:0]);
            left_px   = '0;
            upleft_px = '0;
            col       = '0;
            phase     = puf_pkg::PH_RED;
          end
          puf_pkg::PH_RED: begin
            red_green[15:8] = in_data_byte;
            phase           = puf_pkg::PH_GREEN;
          end
          puf_pkg::PH_GREEN: begin
            red_green[7:0] = in_data_byte;
            phase          = puf_pkg::PH_BLUE;
          end
          default: begin
            w = (width_reg == 0) ? 1 :
                (width_reg > puf_pkg::MAX_WIDTH_DEF) ? puf_pkg::MAX_WIDTH_DEF : int'(width_reg);
            h = (height_reg == 0) ? 1 : int'(height_reg);
            // first row of an image sees zero above
            up_px = (row != 0) ? line_buf[col] : '0;
            raw   = {red_green, in_data_byte};
            for (int k = 0; k < 3; k++)
              px[8*k +: 8] = raw[8*k +: 8] + filter_prediction(row_flt, left_px[8*k +: 8],
                                                                up_px[8*k +: 8],
                                                                upleft_px[8*k +: 8]);
            line_buf[col] = px;
            left_px       = px;
            upleft_px     = up_px;
            last_col      = (int'(col) + 1 >= w);
            last_row      = last_col && (int'(row) + 1 >= h);
            want          = '{px[23:16], px[15:8], px[7:0], col, last_col, last_row};
            pixel_due_q   = {pixel_due_q, want};
            if (last_col) begin
              phase = puf_pkg::PH_FILTER;
              col   = '0;
              row   = last_row ? '0 : row + 1'b1;
            end else begin
              col   = col + 1'b1;
              phase = puf_pkg::PH_RED;
            end
          end
        endcase
      end

      if (out_valid && out_ready) begin
        if (pixel_due_q.size() == 0) begin
          report_mismatch($sformatf("pixel at column %0d with nothing outstanding",
                                    out_column));
        end else begin
          want = pixel_due_q.pop_front();
          check_field("red", 16'(want.red), 16'(out_red));
          check_field("green", 16'(want.green), 16'(out_green));
          check_field("blue", 16'(want.blue), 16'(out_blue));
          check_field("column", 16'(want.column), 16'(out_column));
          check_field("row_end", 16'(want.row_end), 16'(out_row_end));
          check_field("image_end", 16'(want.image_end), 16'(out_image_end));
          pixels_checked++;
        end
      end
    end
    pending = pixel_due_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the PNG RGB8 scanline unfilter testbench: clock, reset, byte stream and register writes.
// Depends on puf_pkg, png_rgb8_scanline_unfilter_unit and unfilter_pixel_checker.
module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BYTES = 1800;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_SETTLE  = 8;
  localparam int END_SETTLE   = 16;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             in_valid     = 1'b0;
  logic [7:0]                       in_data_byte = 8'd0;
  logic                             out_ready    = 1'b0;
  logic                             cfg_we       = 1'b0;
  logic [puf_pkg::CFG_IDX_W-1:0]    cfg_index    = puf_pkg::REG_IMAGE_WIDTH;
  logic [puf_pkg::CFG_DATA_W-1:0]   cfg_wdata    = '0;
  logic                             in_ready;
  logic                             out_valid;
  logic [7:0]                       out_red;
  logic [7:0]                       out_green;
  logic [7:0]                       out_blue;
  logic [puf_pkg::COLUMN_OUT_W-1:0] out_column;
  logic                             out_row_end;
  logic                             out_image_end;

  int     fail_count;
  int     pending;
  int     pixels_checked;
  int     cycles       = 0;
  int     bytes_sent   = 0;
  bit     send_idle_en = 1'b1;
  bit     recv_idle_en = 1'b1;
  bit     long_hold    = 1'b0;
  int     hold_cycles  = 0;

  // stream position as the stimulus sees it, so width only grows at an image start
  int              reg_w     = 1;
  int              reg_h     = 1;
  puf_pkg::phase_t pos_phase = puf_pkg::PH_FILTER;
  int              pos_col   = 0;
  int              pos_row   = 0;

  png_rgb8_scanline_unfilter_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_column   (out_column),
    .out_row_end  (out_row_end),
    .out_image_end(out_image_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  unfilter_pixel_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_column    (out_column),
    .out_row_end   (out_row_end),
    .out_image_end (out_image_end),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .pixels_checked(pixels_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off once requested
  always @(negedge clk) begin
    if (long_hold && hold_cycles < HOLD_CYCLES) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_ready <= !(recv_idle_en && $urandom_range(99) < 16);
    end
  end

  function automatic int eff_width(input int w);
    return (w == 0) ? 1 : (w > puf_pkg::MAX_WIDTH_DEF) ? puf_pkg::MAX_WIDTH_DEF : w;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_en && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
    case (pos_phase)
      puf_pkg::PH_FILTER: begin
        pos_col   = 0;
        pos_phase = puf_pkg::PH_RED;
      end
      puf_pkg::PH_RED:   pos_phase = puf_pkg::PH_GREEN;
      puf_pkg::PH_GREEN: pos_phase = puf_pkg::PH_BLUE;
      default: begin
        if (pos_col + 1 >= eff_width(reg_w)) begin
          pos_phase = puf_pkg::PH_FILTER;
          pos_col   = 0;
          pos_row   = (pos_row + 1 >= ((reg_h == 0) ? 1 : reg_h)) ? 0 : pos_row + 1;
        end else begin
          pos_col++;
          pos_phase = puf_pkg::PH_RED;
        end
      end
    endcase
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    send_byte(r);
    send_byte(g);
    send_byte(b);
  endtask

  // stop offering and let every outstanding pixel come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [puf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [puf_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == puf_pkg::REG_IMAGE_WIDTH) reg_w = int'(val[puf_pkg::IMG_WIDTH_W-1:0]);
    else reg_h = int'(val);
  endtask

  task automatic configure(input int w, input int h);
    wait_idle();
    write_reg(puf_pkg::REG_IMAGE_WIDTH, 16'(w));
    write_reg(puf_pkg::REG_IMAGE_HEIGHT, 16'(h));
  endtask

  task automatic send_row();
    logic [7:0] flt_byte;
    int         r;
    if ($urandom_range(99) < 90) flt_byte = 8'($urandom_range(int'(puf_pkg::FLT_PAETH)));
    else flt_byte = 8'($urandom_range(255, int'(puf_pkg::FILTER_MAX_CODE) + 1));
    send_byte(flt_byte);
    while (pos_phase != puf_pkg::PH_FILTER) begin
      r = $urandom_range(19);
      send_byte((r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
    end
  endtask

  task automatic send_image();
    do begin
      send_row();
      // now and then change height, or narrow the row, part-way through an image
      if (pos_row != 0 && $urandom_range(99) < 4) begin
        wait_idle();
        if ($urandom_range(1) == 1)
          write_reg(puf_pkg::REG_IMAGE_HEIGHT, 16'($urandom_range(5)));
        else write_reg(puf_pkg::REG_IMAGE_WIDTH, 16'($urandom_range(eff_width(reg_w))));
      end
    end while (pos_row != 0);
  endtask

  initial begin
    int random_start;
    int r;
    int w;
    int h;
    bit calm;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // None, Sub, Average and Paeth filters on a two-pixel-wide image, channel extremes and wrap-around
    configure(2, 4);
    send_byte(8'(puf_pkg::FLT_NONE));
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h01, 8'h80);
    send_byte(8'(puf_pkg::FLT_SUB));
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'hFF, 8'hFE, 8'h7F);
    send_byte(8'(puf_pkg::FLT_AVG));
    send_pixel(8'h01, 8'hFF, 8'h00);
    send_pixel(8'h7F, 8'h80, 8'h81);
    send_byte(8'(puf_pkg::FLT_PAETH));
    send_pixel(8'h10, 8'hF0, 8'h33);
    send_pixel(8'h00, 8'hFF, 8'h80);

    // zero width and height act as one; unknown filter code
    configure(0, 0);
    send_byte(8'hFF);
    send_pixel(8'h12, 8'h34, 8'h56);

    // tallest image, then narrowed mid-row and cut short mid-image
    configure(3, 16'hFFFF);
    send_byte(8'(puf_pkg::FLT_UP));
    send_pixel(8'h80, 8'h7F, 8'hFF);
    send_pixel(8'h01, 8'h00, 8'hFE);
    send_pixel(8'hC3, 8'h3C, 8'h5A);
    send_byte(8'(puf_pkg::FLT_UP));
    send_pixel(8'hFF, 8'h80, 8'h01);
    wait_idle();
    write_reg(puf_pkg::REG_IMAGE_WIDTH, 16'd1);
    send_pixel(8'h00, 8'hFF, 8'h10);
    wait_idle();
    write_reg(puf_pkg::REG_IMAGE_HEIGHT, 16'd0);
    send_byte(8'(puf_pkg::FLT_UP));
    send_pixel(8'h55, 8'hAA, 8'h0F);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      calm = (bytes_sent - random_start >= 900) && (bytes_sent - random_start < 1300);
      send_idle_en <= !calm;
      recv_idle_en <= !calm;
      if (!long_hold && bytes_sent - random_start >= 500) begin
        configure(40, 2);
        long_hold <= 1'b1;
      end else if ($urandom_range(99) < 70) begin
        r = $urandom_range(99);
        w = (r < 70) ? $urandom_range(1, 6) : (r < 90) ? $urandom_range(7, 48) :
            (r < 95) ? 0 : $urandom_range(49, 64);
        r = $urandom_range(99);
        h = (r < 85) ? $urandom_range(1, 4) : (r < 95) ? 0 : $urandom_range(5, 6);
        configure(w, h);
      end
      send_image();
    end

    // width register above the buffer size, row then ended by narrowing
    send_idle_en <= 1'b1;
    recv_idle_en <= 1'b1;
    configure(2047, 1);
    send_byte(8'(puf_pkg::FLT_AVG));
    repeat (4) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    wait_idle();
    write_reg(puf_pkg::REG_IMAGE_WIDTH, 16'd1);
    send_pixel(8'hA5, 8'h5A, 8'hFF);

    wait_idle();
    repeat (END_SETTLE) @(negedge clk);
    $display("Streamed %0d bytes, %0d pixels checked: all filters, unknown codes, widths 0..2047",
             bytes_sent, pixels_checked);
    $display("and heights 0..65535, register changes within images, long result stalls.");
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
